FILE: src/tplc_pkg.sv
`default_nettype none
package tplc_pkg;

  localparam int unsigned TimeoutW = 24;
  localparam int unsigned BlinkW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [TimeoutW-1:0] TimeoutRst  = 24'd600000;
  localparam logic [BlinkW-1:0]   BlinkHalfRst = 16'd500;
  localparam logic [TimeoutW-1:0] ElapsedMax  = {TimeoutW{1'b1}};

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegRunTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBlinkHalf  = 2'd1;

  // mode codes as seen on mode_out
  localparam logic [1:0] ModeCodeOff = 2'd0;
  localparam logic [1:0] ModeCodeRun = 2'd1;
  localparam logic [1:0] ModeCodeEmg = 2'd2;

  typedef enum logic [2:0] {
    MODE_OFF = 3'b001,
    MODE_RUN = 3'b010,
    MODE_EMG = 3'b100
  } mode_e;

  typedef struct packed {
    logic level_top;
    logic level_upper_mid;
    logic level_lower_mid;
    logic level_bottom;
    logic panic_button;
    logic manual_start;
  } tick_t;

  typedef struct packed {
    logic       pump_drive;
    logic       lamp_top;
    logic       lamp_upper_mid;
    logic       lamp_lower_mid;
    logic       lamp_bottom;
    logic [1:0] mode_out;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

endpackage
`default_nettype wire

FILE: src/tplc_if.sv
`default_nettype none
interface tplc_tick_if;
  import tplc_pkg::*;
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tplc_result_if;
  import tplc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tplc_cfg_if;
  import tplc_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/tank_pump_level_controller.sv
`default_nettype none
// Channel   Dir  Payload                               Beat taken when
// tick_i    in   four level switches, panic, manual    valid & ready
// result_o  out  pump drive, four lamps, mode code     valid & ready
// cfg_i     in   register index, write data            valid & ready (ready always high)
//
// One tick beat per cycle. The mode, run counter and blink state update at the
// accepting edge; the result sits in a one-deep output register, so the next
// tick is taken in the same cycle as the held result is drained.
// Reset clears the mode to off, the counters to zero, the blink phase to lit
// and loads the default timeout and half period. A stalled output only holds
// off new ticks while the register is full and not being taken.
module tank_pump_level_controller
  import tplc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tplc_tick_if.sink     tick_i,
  tplc_result_if.source result_o,
  tplc_cfg_if.sink      cfg_i
);

  // configuration
  logic [TimeoutW-1:0] timeout_q;
  logic [BlinkW-1:0]   blink_half_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TimeoutRst;
      blink_half_q <= BlinkHalfRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        RegRunTimeout: timeout_q    <= cfg_i.data.wdata[TimeoutW-1:0];
        RegBlinkHalf:  blink_half_q <= cfg_i.data.wdata[BlinkW-1:0];
        default: ;
      endcase
    end
  end

  // state
  mode_e               mode_q, mode_d;
  logic [TimeoutW-1:0] elapsed_q, elapsed_d;
  logic [BlinkW-1:0]   blink_cnt_q, blink_cnt_d;
  logic                phase_q, phase_d;

  logic    out_valid_q;
  result_t out_q, out_d;
  logic    take;

  assign tick_i.ready = !out_valid_q || result_o.ready;
  assign take         = tick_i.valid && tick_i.ready;

  logic [TimeoutW-1:0] elapsed_inc;
  logic [BlinkW:0]     blink_inc;

  always_comb begin
    tick_t t;
    t           = tick_i.data;
    mode_d      = mode_q;
    elapsed_d   = elapsed_q;
    blink_cnt_d = blink_cnt_q;
    phase_d     = phase_q;
    elapsed_inc = (elapsed_q != ElapsedMax) ? elapsed_q + 1'b1 : elapsed_q;
    blink_inc   = {1'b0, blink_cnt_q} + 1'b1;

    case (mode_q)
      MODE_OFF: begin
        if ((!t.level_top && !t.level_bottom) || t.manual_start) begin
          mode_d    = MODE_RUN;
          elapsed_d = '0;
        end
      end
      MODE_RUN: begin
        elapsed_d = elapsed_inc;
        if (t.level_top) mode_d = MODE_OFF;
        // timeout wins over a wet top switch
        if (elapsed_inc > timeout_q) mode_d = MODE_EMG;
      end
      default: mode_d = MODE_EMG;
    endcase

    if (t.panic_button) mode_d = MODE_EMG;

    out_d.pump_drive = (mode_d == MODE_RUN);
    if (mode_d == MODE_EMG) begin
      out_d.lamp_top       = phase_q;
      out_d.lamp_upper_mid = phase_q;
      out_d.lamp_lower_mid = phase_q;
      out_d.lamp_bottom    = phase_q;
      // zero half period acts as one: toggle every tick
      if (blink_inc >= {1'b0, blink_half_q}) begin
        blink_cnt_d = '0;
        phase_d     = !phase_q;
      end else begin
        blink_cnt_d = blink_inc[BlinkW-1:0];
      end
    end else begin
      out_d.lamp_top       = t.level_top;
      out_d.lamp_upper_mid = t.level_upper_mid;
      out_d.lamp_lower_mid = t.level_lower_mid;
      out_d.lamp_bottom    = t.level_bottom;
    end

    case (mode_d)
      MODE_OFF: out_d.mode_out = ModeCodeOff;
      MODE_RUN: out_d.mode_out = ModeCodeRun;
      default:  out_d.mode_out = ModeCodeEmg;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OFF;
      elapsed_q   <= '0;
      blink_cnt_q <= '0;
      phase_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q      <= mode_d;
        elapsed_q   <= elapsed_d;
        blink_cnt_q <= blink_cnt_d;
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= out_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule
`default_nettype wire
